// ===== sv/cia_pkg.sv =====
`timescale 1ns / 1ps

package cia_pkg;

  // Unsigned Q15 one.
  localparam logic [16:0] Q15_ONE = 17'd32768;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_INTENSITY_STEP = 3'd0;
  localparam logic [2:0] REG_COLL_MAX_STEP  = 3'd1;
  localparam logic [2:0] REG_SMOOTH_ALPHA   = 3'd2;
  localparam logic [2:0] REG_RECENTER_ALPHA = 3'd3;
  localparam logic [2:0] REG_DEADZONE       = 3'd4;
  localparam logic [2:0] REG_AT_GAIN        = 3'd5;

  typedef struct packed {
    logic        [15:0] intensity_step;
    logic        [15:0] coll_max_step;
    logic        [15:0] smooth_alpha;
    logic        [15:0] recenter_alpha;
    logic        [14:0] deadzone;
    logic signed [15:0] at_gain;
  } cia_cfg_t;

  // Control of the shared multiply unit.
  typedef struct packed {
    logic load;       // capture operands and product this cycle
    logic gain_shift; // round back by 12 instead of 15
  } lpu_ctl_t;

  // Operations of one assisted frame, in issue order.
  typedef enum logic [2:0] {
    OP_LAT  = 3'd0,
    OP_LON  = 3'd1,
    OP_PED  = 3'd2,
    OP_GAIN = 3'd3,
    OP_BLAT = 3'd4,
    OP_BLON = 3'd5,
    OP_BPED = 3'd6,
    OP_BCOL = 3'd7
  } op_t;

  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    logic signed [15:0] r;
    if (v > 35'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/cia_cfg.sv =====
`timescale 1ns / 1ps

module cia_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output cia_pkg::cia_cfg_t cfg
);

  cia_pkg::cia_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.intensity_step <= 16'd1092;
      cfg_r.coll_max_step  <= 16'd546;
      cfg_r.smooth_alpha   <= 16'd8192;
      cfg_r.recenter_alpha <= 16'd2048;
      cfg_r.deadzone       <= 15'd1638;
      cfg_r.at_gain        <= 16'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cia_pkg::REG_INTENSITY_STEP: cfg_r.intensity_step <= cfg_data;
        cia_pkg::REG_COLL_MAX_STEP:  cfg_r.coll_max_step  <= cfg_data;
        cia_pkg::REG_SMOOTH_ALPHA:   cfg_r.smooth_alpha   <= cfg_data;
        cia_pkg::REG_RECENTER_ALPHA: cfg_r.recenter_alpha <= cfg_data;
        cia_pkg::REG_DEADZONE:       cfg_r.deadzone       <= cfg_data[14:0];
        cia_pkg::REG_AT_GAIN:        cfg_r.at_gain        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/cia_lpu.sv =====
`timescale 1ns / 1ps

// Shared unit: prev + round(d * f / 2^s), saturated to 16 bits.
// The product is registered; the rounding add follows in the next cycle.
module cia_lpu (
  input  logic                clk,
  input  cia_pkg::lpu_ctl_t   ctl,
  input  logic signed [15:0]  prev,
  input  logic signed [16:0]  d,
  input  logic signed [16:0]  f,
  output logic signed [15:0]  result
);

  logic signed [33:0] prod_r;
  logic signed [15:0] prev_r;
  logic               sh12_r;
  logic signed [34:0] rnd;
  logic signed [34:0] shifted;
  logic signed [34:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= d * f;
      prev_r <= prev;
      sh12_r <= ctl.gain_shift;
    end
  end

  // Adding half and shifting arithmetically rounds to nearest, ties upward.
  always_comb begin
    rnd     = {prod_r[33], prod_r} + (sh12_r ? 35'sd2048 : 35'sd16384);
    shifted = sh12_r ? (rnd >>> 12) : (rnd >>> 15);
    sum     = shifted + 35'(prev_r);
    result  = cia_pkg::sat16(sum);
  end

endmodule

// ===== sv/control_input_assist_filter_core.sv =====
`timescale 1ns / 1ps

// Pilot control assist filter, one control frame per input word.
// Input channel: in_valid/in_stall with four raw Q1.15 axes and assist_on.
// Output channel: out_valid/out_stall with the four blended axes, one word
// for every input word. Configuration: cfg_valid/cfg_ready write port, index
// and 16-bit data; cfg_ready is always high. Write only while the block idles.
// A frame at zero assist intensity skips the multiplier and goes from acceptance
// straight to the output state, which loads the output register.
// An assisted frame: intensity and collective slew are computed at acceptance,
// then eight passes of the shared multiplier follow (a multiply state and a
// round-and-saturate state each), then the output state loads the output
// register and the block returns to idle. in_stall stays high while a frame
// is in work, so one frame is in flight at a time; a finished word may wait
// in the output register while the next frame is taken.
// When out_stall is high and the output register still holds a word, the finished
// frame waits before the output register and the block takes no new frame until it moves on.
// Reset (rst_n low, synchronous) restores the default registers, zeroes the
// assist intensity and the filter state, and empties the output register.
module control_input_assist_filter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_cyclic_lateral,
  input  logic signed [15:0] in_cyclic_longitudinal,
  input  logic signed [15:0] in_pedal_input,
  input  logic signed [15:0] in_collective_input,
  input  logic               in_assist_on,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_lateral,
  output logic signed [15:0] out_longitudinal,
  output logic signed [15:0] out_pedal,
  output logic signed [15:0] out_collective,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic signed [18:0] Q15_ONE_S = 19'sd32768;

  cia_pkg::cia_cfg_t cfg;
  cia_pkg::lpu_ctl_t lpu_ctl;

  state_t         state_r, state_nxt;
  cia_pkg::op_t   op_r;

  logic [16:0]        level_r, level_nxt;
  logic signed [15:0] held_lat_r, held_lon_r, held_ped_r, held_col_r;
  logic signed [15:0] raw_lat_r, raw_lon_r, raw_ped_r, raw_col_r;
  logic signed [15:0] coll_r, pa_r;
  logic signed [16:0] dcoll_r;
  logic               active_r;
  logic signed [15:0] res_lat_r, res_lon_r, res_ped_r, res_col_r;
  logic signed [15:0] out_lat_r, out_lon_r, out_ped_r, out_col_r;
  logic               out_valid_r;

  logic               in_acc;
  logic               out_free;
  logic signed [18:0] lvl_diff, lvl_step, lvl_sum;
  logic signed [17:0] col_diff, col_step, col_sum;
  logic signed [15:0] coll_nxt;
  logic [16:0]        abs_lat, abs_lon;
  logic               active_nxt;

  logic signed [15:0] lp_prev, lp_tgt, lp_res;
  logic signed [16:0] lp_d, lp_f;
  logic               lp_gain;
  logic [15:0]        cyc_alpha;

  cia_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Intensity update, collective slew and dead-band test, all done on acceptance.
  always_comb begin
    lvl_diff = (in_assist_on ? 19'(Q15_ONE_S) : 19'sd0) - $signed({2'b00, level_r});
    if (lvl_diff > $signed({3'b000, cfg.intensity_step})) begin
      lvl_step = $signed({3'b000, cfg.intensity_step});
    end else if (lvl_diff < -$signed({3'b000, cfg.intensity_step})) begin
      lvl_step = -$signed({3'b000, cfg.intensity_step});
    end else begin
      lvl_step = lvl_diff;
    end
    lvl_sum = $signed({2'b00, level_r}) + lvl_step;
    if (lvl_sum < 19'sd0) begin
      level_nxt = 17'd0;
    end else if (lvl_sum > 19'(Q15_ONE_S)) begin
      level_nxt = cia_pkg::Q15_ONE;
    end else begin
      level_nxt = lvl_sum[16:0];
    end

    col_diff = 18'(in_collective_input) - 18'(held_col_r);
    if (col_diff > $signed({2'b00, cfg.coll_max_step})) begin
      col_step = $signed({2'b00, cfg.coll_max_step});
    end else if (col_diff < -$signed({2'b00, cfg.coll_max_step})) begin
      col_step = -$signed({2'b00, cfg.coll_max_step});
    end else begin
      col_step = col_diff;
    end
    col_sum  = 18'(held_col_r) + col_step;
    coll_nxt = cia_pkg::sat16(35'(col_sum));

    abs_lat = in_cyclic_lateral[15] ? 17'(-18'(in_cyclic_lateral))
                                    : 17'(in_cyclic_lateral);
    abs_lon = in_cyclic_longitudinal[15] ? 17'(-18'(in_cyclic_longitudinal))
                                         : 17'(in_cyclic_longitudinal);
    active_nxt = (abs_lat > {2'b00, cfg.deadzone}) || (abs_lon > {2'b00, cfg.deadzone});
  end

  // Operand selection for the shared unit.
  always_comb begin
    cyc_alpha = active_r ? cfg.smooth_alpha : cfg.recenter_alpha;
    lp_gain   = 1'b0;
    lp_f      = $signed({1'b0, level_r[15:0]});
    lp_prev   = raw_lat_r;
    lp_tgt    = held_lat_r;
    case (op_r)
      cia_pkg::OP_LAT: begin
        lp_prev = held_lat_r;
        lp_tgt  = active_r ? raw_lat_r : 16'sd0;
        lp_f    = $signed({1'b0, cyc_alpha});
      end
      cia_pkg::OP_LON: begin
        lp_prev = held_lon_r;
        lp_tgt  = active_r ? raw_lon_r : 16'sd0;
        lp_f    = $signed({1'b0, cyc_alpha});
      end
      cia_pkg::OP_PED: begin
        lp_prev = held_ped_r;
        lp_tgt  = raw_ped_r;
        lp_f    = $signed({1'b0, cfg.smooth_alpha});
      end
      cia_pkg::OP_GAIN: begin
        lp_prev = held_ped_r;
        lp_tgt  = held_ped_r;
        lp_f    = 17'(cfg.at_gain);
        lp_gain = 1'b1;
      end
      cia_pkg::OP_BLAT: begin
        lp_prev = raw_lat_r;
        lp_tgt  = held_lat_r;
      end
      cia_pkg::OP_BLON: begin
        lp_prev = raw_lon_r;
        lp_tgt  = held_lon_r;
      end
      cia_pkg::OP_BPED: begin
        lp_prev = raw_ped_r;
        lp_tgt  = pa_r;
      end
      cia_pkg::OP_BCOL: begin
        lp_prev = raw_col_r;
        lp_tgt  = coll_r;
      end
      default: ;
    endcase
    // Intensity of exactly one needs the 17th bit.
    if (op_r == cia_pkg::OP_BLAT || op_r == cia_pkg::OP_BLON ||
        op_r == cia_pkg::OP_BPED || op_r == cia_pkg::OP_BCOL) begin
      lp_f = $signed(level_r);
    end
    lp_d = lp_gain ? dcoll_r : (17'(lp_tgt) - 17'(lp_prev));
  end

  assign lpu_ctl.load       = (state_r == ST_MUL);
  assign lpu_ctl.gain_shift = lp_gain;

  cia_lpu u_lpu (
    .clk    (clk),
    .ctl    (lpu_ctl),
    .prev   (lp_prev),
    .d      (lp_d),
    .f      (lp_f),
    .result (lp_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (level_nxt == 17'd0) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (op_r == cia_pkg::OP_BCOL) ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= cia_pkg::OP_LAT;
      level_r     <= 17'd0;
      held_lat_r  <= 16'sd0;
      held_lon_r  <= 16'sd0;
      held_ped_r  <= 16'sd0;
      held_col_r  <= 16'sd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_acc) begin
        level_r <= level_nxt;
        op_r    <= cia_pkg::OP_LAT;
        if (level_nxt == 17'd0) begin
          held_lat_r <= in_cyclic_lateral;
          held_lon_r <= in_cyclic_longitudinal;
          held_ped_r <= in_pedal_input;
          held_col_r <= in_collective_input;
        end else begin
          held_col_r <= coll_nxt;
        end
      end

      if (state_r == ST_ACC) begin
        op_r <= cia_pkg::op_t'(op_r + 3'd1);
        case (op_r)
          cia_pkg::OP_LAT: held_lat_r <= lp_res;
          cia_pkg::OP_LON: held_lon_r <= lp_res;
          cia_pkg::OP_PED: held_ped_r <= lp_res;
          default: ;
        endcase
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame payload and working values.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_lat_r <= in_cyclic_lateral;
      raw_lon_r <= in_cyclic_longitudinal;
      raw_ped_r <= in_pedal_input;
      raw_col_r <= in_collective_input;
      coll_r    <= coll_nxt;
      dcoll_r   <= 17'(coll_nxt) - 17'(held_col_r);
      active_r  <= active_nxt;
      res_lat_r <= in_cyclic_lateral;
      res_lon_r <= in_cyclic_longitudinal;
      res_ped_r <= in_pedal_input;
      res_col_r <= in_collective_input;
    end
    if (state_r == ST_ACC) begin
      case (op_r)
        cia_pkg::OP_GAIN: pa_r      <= lp_res;
        cia_pkg::OP_BLAT: res_lat_r <= lp_res;
        cia_pkg::OP_BLON: res_lon_r <= lp_res;
        cia_pkg::OP_BPED: res_ped_r <= lp_res;
        cia_pkg::OP_BCOL: res_col_r <= lp_res;
        default: ;
      endcase
    end
    if (state_r == ST_OUT && out_free) begin
      out_lat_r <= res_lat_r;
      out_lon_r <= res_lon_r;
      out_ped_r <= res_ped_r;
      out_col_r <= res_col_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lateral      = out_lat_r;
  assign out_longitudinal = out_lon_r;
  assign out_pedal        = out_ped_r;
  assign out_collective   = out_col_r;

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= cia_pkg::Q15_ONE)
    else $error("assist intensity above one");

  a_assist_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && level_nxt != 17'd0) |=> (state_r == ST_MUL && op_r == cia_pkg::OP_LAT))
    else $error("assisted frame did not start the multiply sequence");

  a_pass_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && level_nxt == 17'd0) |=> state_r == ST_OUT)
    else $error("pass-through frame entered the multiply sequence");

  a_seq_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && op_r == cia_pkg::OP_BCOL) |=> state_r == ST_OUT)
    else $error("sequence did not finish after the last blend");
`endif

endmodule

// ===== tb/cia_frame_checker.sv =====
`timescale 1ns / 1ps

module cia_frame_checker
  import cia_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_cyclic_lateral,
  input  logic signed [15:0] in_cyclic_longitudinal,
  input  logic signed [15:0] in_pedal_input,
  input  logic signed [15:0] in_collective_input,
  input  logic               in_assist_on,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_lateral,
  input  logic signed [15:0] out_longitudinal,
  input  logic signed [15:0] out_pedal,
  input  logic signed [15:0] out_collective,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatch_count,
  output int                 frames_in_flight
);

  typedef struct {
    int lat;
    int lon;
    int ped;
    int col;
  } frame_axes_t;

  // Configuration copy.
  int assist_step;
  int slew_step;
  int cmd_alpha;
  int center_alpha;
  int dead_band;
  int yaw_gain;

  // Assist intensity and filter state.
  int intensity;
  int hold_lat;
  int hold_lon;
  int hold_ped;
  int hold_col;

  frame_axes_t blended_frames[$];
  int mismatches = 0;

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int sat_q15(longint v);
    return int'(bound(v, -32768, 32767));
  endfunction

  // Round half up, then drop s fraction bits (arithmetic shift floors).
  function automatic longint round_drop(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int lowpass(int prev, int target, longint alpha);
    return sat_q15(longint'(prev) + round_drop((longint'(target) - prev) * alpha, 15));
  endfunction

  function automatic frame_axes_t assist_frame(int r_lat, int r_lon, int r_ped, int r_col,
                                               bit on);
    frame_axes_t f;
    longint goal;
    int coll;
    int dcoll;
    int ped_assist;
    int alpha;
    bit active;
    goal = on ? 32768 : 0;
    intensity = int'(bound(intensity + bound(goal - intensity, -longint'(assist_step),
                                             assist_step), 0, 32768));
    if (intensity == 0) begin
      hold_lat = r_lat;
      hold_lon = r_lon;
      hold_ped = r_ped;
      hold_col = r_col;
      f = '{r_lat, r_lon, r_ped, r_col};
    end else begin
      coll = sat_q15(hold_col + bound(longint'(r_col) - hold_col, -longint'(slew_step),
                                      slew_step));
      dcoll = coll - hold_col;
      // Magnitude of -32768 is 32768, so it is always outside the dead band.
      active = ((r_lat < 0) ? -r_lat : r_lat) > dead_band ||
               ((r_lon < 0) ? -r_lon : r_lon) > dead_band;
      alpha = active ? cmd_alpha : center_alpha;
      hold_lat = lowpass(hold_lat, active ? r_lat : 0, alpha);
      hold_lon = lowpass(hold_lon, active ? r_lon : 0, alpha);
      hold_ped = lowpass(hold_ped, r_ped, cmd_alpha);
      ped_assist = sat_q15(longint'(hold_ped) + round_drop(longint'(dcoll) * yaw_gain, 12));
      hold_col = coll;
      f.lat = lowpass(r_lat, hold_lat, intensity);
      f.lon = lowpass(r_lon, hold_lon, intensity);
      f.ped = lowpass(r_ped, ped_assist, intensity);
      f.col = lowpass(r_col, coll, intensity);
    end
    return f;
  endfunction

  task automatic compare_axis(string name, int want, logic signed [15:0] got);
    logic signed [15:0] want16;
    want16 = want[15:0];
    if (got !== want16) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, want16, got);
    end
  endtask

  always @(posedge clk) begin
    frame_axes_t want;
    if (!rst_n) begin
      assist_step  = 1092;
      slew_step    = 546;
      cmd_alpha    = 8192;
      center_alpha = 2048;
      dead_band    = 1638;
      yaw_gain     = 0;
      intensity    = 0;
      hold_lat     = 0;
      hold_lon     = 0;
      hold_ped     = 0;
      hold_col     = 0;
      blended_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INTENSITY_STEP: assist_step  = int'(cfg_data);
          REG_COLL_MAX_STEP:  slew_step    = int'(cfg_data);
          REG_SMOOTH_ALPHA:   cmd_alpha    = int'(cfg_data);
          REG_RECENTER_ALPHA: center_alpha = int'(cfg_data);
          REG_DEADZONE:       dead_band    = int'(cfg_data[14:0]);
          REG_AT_GAIN:        yaw_gain     = int'($signed(cfg_data));
          default: ;
        endcase
      end
      // A result word always belongs to a frame accepted at an earlier edge.
      if (out_valid && !out_stall) begin
        if (blended_frames.size() == 0) begin
          mismatches++;
          $error("result word with no frame outstanding");
        end else begin
          want = blended_frames.pop_front();
          compare_axis("out_lateral", want.lat, out_lateral);
          compare_axis("out_longitudinal", want.lon, out_longitudinal);
          compare_axis("out_pedal", want.ped, out_pedal);
          compare_axis("out_collective", want.col, out_collective);
        end
      end
      if (in_valid && !in_stall) begin
        blended_frames.push_back(assist_frame(in_cyclic_lateral, in_cyclic_longitudinal,
                                              in_pedal_input, in_collective_input,
                                              in_assist_on));
      end
    end
    mismatch_count   <= mismatches;
    frames_in_flight <= blended_frames.size();
  end

endmodule

// ===== tb/tb_control_input_assist_filter_core.sv =====
`timescale 1ns / 1ps

module tb_control_input_assist_filter_core;
  import cia_pkg::*;

  typedef enum {AXIS_WALK, AXIS_NOISE, AXIS_NEAR_CENTER, AXIS_RAIL} axis_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_cyclic_lateral = '0;
  logic signed [15:0] in_cyclic_longitudinal = '0;
  logic signed [15:0] in_pedal_input = '0;
  logic signed [15:0] in_collective_input = '0;
  logic               in_assist_on = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_lateral;
  logic signed [15:0] out_longitudinal;
  logic signed [15:0] out_pedal;
  logic signed [15:0] out_collective;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int mismatch_count;
  int frames_in_flight;
  int idle_pct = 18;
  int dz_now = 1638;
  int stick[4] = '{0, 0, 0, 0};

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  control_input_assist_filter_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_cyclic_lateral      (in_cyclic_lateral),
    .in_cyclic_longitudinal (in_cyclic_longitudinal),
    .in_pedal_input         (in_pedal_input),
    .in_collective_input    (in_collective_input),
    .in_assist_on           (in_assist_on),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_lateral            (out_lateral),
    .out_longitudinal       (out_longitudinal),
    .out_pedal              (out_pedal),
    .out_collective         (out_collective),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  cia_frame_checker i_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_cyclic_lateral      (in_cyclic_lateral),
    .in_cyclic_longitudinal (in_cyclic_longitudinal),
    .in_pedal_input         (in_pedal_input),
    .in_collective_input    (in_collective_input),
    .in_assist_on           (in_assist_on),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_lateral            (out_lateral),
    .out_longitudinal       (out_longitudinal),
    .out_pedal              (out_pedal),
    .out_collective         (out_collective),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .mismatch_count         (mismatch_count),
    .frames_in_flight       (frames_in_flight)
  );

  task automatic send_frame(int lat, int lon, int ped, int col, bit on);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_cyclic_lateral      <= lat[15:0];
    in_cyclic_longitudinal <= lon[15:0];
    in_pedal_input         <= ped[15:0];
    in_collective_input    <= col[15:0];
    in_assist_on           <= on;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every word in flight has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(cia_cfg_t s);
    write_reg(REG_INTENSITY_STEP, s.intensity_step);
    write_reg(REG_COLL_MAX_STEP, s.coll_max_step);
    write_reg(REG_SMOOTH_ALPHA, s.smooth_alpha);
    write_reg(REG_RECENTER_ALPHA, s.recenter_alpha);
    write_reg(REG_DEADZONE, {1'b0, s.deadzone});
    write_reg(REG_AT_GAIN, s.at_gain);
    cfg_valid <= 1'b0;
    dz_now = int'(s.deadzone);
  endtask

  // Coefficients above one are legal register values and are exercised too.
  function automatic cia_cfg_t random_settings(bit beyond_one);
    cia_cfg_t s;
    s.intensity_step = 16'(beyond_one ? $urandom_range(32769, 65535)
                                      : $urandom_range(300, 6000));
    s.coll_max_step  = 16'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 3000));
    s.smooth_alpha   = 16'(beyond_one ? $urandom_range(32769, 65535)
                                      : $urandom_range(0, 32768));
    s.recenter_alpha = 16'(beyond_one ? $urandom_range(32769, 65535)
                                      : $urandom_range(0, 32768));
    s.deadzone       = 15'($urandom_range(0, 6000));
    s.at_gain        = 16'($urandom());
    return s;
  endfunction

  function automatic int next_axis(axis_mode_t mode, int prev);
    int v;
    int m;
    logic [15:0] raw;
    case (mode)
      AXIS_WALK: v = prev + int'($urandom_range(0, 4000)) - 2000;
      AXIS_NOISE: begin
        raw = 16'($urandom());
        v = int'($signed(raw));
      end
      AXIS_NEAR_CENTER: begin
        m = dz_now + 2;
        v = int'($urandom_range(0, 2 * m)) - m;
      end
      default: begin
        case ($urandom_range(5))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -32767;
          4: v = 1;
          default: v = -1;
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Runs of frames with a mostly steady assist request (flipped in 5 percent of frames),
  // so the intensity ramps up or down, with each axis following its own kind of motion per run.
  task automatic random_phase(int count);
    int n;
    int run;
    int k;
    int a;
    bit on;
    axis_mode_t mode[4];
    n = 0;
    while (n < count) begin
      run = $urandom_range(1, 60);
      on = ($urandom_range(99) < 70);
      for (a = 0; a < 4; a++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: mode[a] = AXIS_WALK;
          5, 6:          mode[a] = AXIS_NEAR_CENTER;
          7, 8:          mode[a] = AXIS_NOISE;
          default:       mode[a] = AXIS_RAIL;
        endcase
      end
      for (k = 0; k < run && n < count; k++) begin
        for (a = 0; a < 4; a++) stick[a] = next_axis(mode[a], stick[a]);
        send_frame(stick[0], stick[1], stick[2], stick[3],
                   on ^ ($urandom_range(99) < 5));
        n++;
      end
    end
  endtask

  initial begin
    cia_cfg_t s;
    int p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Default settings: pass-through at the rails, then a gentle ramp-in
    // around the dead band edge.
    send_frame(32767, -32768, 32767, -32768, 1'b0);
    send_frame(0, 0, 0, 0, 1'b0);
    send_frame(-32768, 32767, -32768, 32767, 1'b0);
    send_frame(1000, -1000, 5000, 8000, 1'b1);
    send_frame(1638, -1638, -5000, 8000, 1'b1);
    send_frame(1639, 0, 12000, -20000, 1'b1);
    send_frame(-32768, -32768, 32767, 32767, 1'b1);
    send_frame(0, -1639, -32768, -32768, 1'b0);
    drain();

    // Steps and coefficients above one, widest dead band, largest positive gain.
    s = '{16'hffff, 16'hffff, 16'hffff, 16'd40000, 15'h7fff, 16'sh7fff};
    load_settings(s);
    send_frame(-32768, 0, 32767, 32767, 1'b1);
    send_frame(32767, 32767, 32767, -32768, 1'b1);
    send_frame(32767, -32768, 32767, 32767, 1'b1);
    send_frame(-32768, 32767, -32768, -32768, 1'b1);
    send_frame(0, 0, 0, 0, 1'b0);
    send_frame(100, -100, 32767, -32768, 1'b1);
    send_frame(-32767, 32767, -32768, 32767, 1'b1);
    send_frame(5, 5, 5, 5, 1'b0);
    drain();

    s = '{16'd32768, 16'd546, 16'd8192, 16'd2048, 15'd1638, 16'sh8000};
    load_settings(s);
    send_frame(20000, 0, 32767, -32768, 1'b1);
    send_frame(0, 0, -32768, 32767, 1'b1);
    send_frame(-20000, 3000, 0, 32767, 1'b1);
    drain();

    for (p = 0; p < 7; p++) begin
      case (p)
        1:       s = '{16'd32768, 16'hffff, 16'd32768, 16'd32768, 15'h7fff, 16'sh7fff};
        2:       s = '{16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 16'sh8000};
        3:       s = random_settings(1'b1);
        default: s = random_settings(1'b0);
      endcase
      load_settings(s);
      // One whole phase runs with neither side idling.
      idle_pct = (p == 1) ? 0 : 18;
      random_phase(230);
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cia_pkg.sv
sv/cia_cfg.sv
sv/cia_lpu.sv
sv/control_input_assist_filter_core.sv
tb/cia_frame_checker.sv
tb/tb_control_input_assist_filter_core.sv
